// ===== rtl/kmds_pkg.sv =====
// Shared types and constants of the keypad matrix debounce scanner.
package kmds_pkg;

  // Field widths fixed by the item formats
  localparam int KEY_W = 5;
  localparam int CNT_W = 3;
  localparam int REG_IDX_W = 2;

  localparam logic [KEY_W-1:0] SPECIAL_INDEX = 5'd16;
  localparam logic [KEY_W-1:0] SLOT_NONE     = 5'd16;
  localparam logic [KEY_W-1:0] THR_RESET     = 5'd3;

  // Register indexes of the configuration port
  localparam logic [REG_IDX_W-1:0] REG_START_SLOT = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_F1_SLOT    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_F2_SLOT    = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_COMBO_THR  = 2'd3;

  typedef struct packed {
    logic [KEY_W-1:0] start_slot;
    logic [KEY_W-1:0] f1_slot;
    logic [KEY_W-1:0] f2_slot;
    logic [KEY_W-1:0] combo_thr;
  } cfg_t;

  // What one lane found for the current sample
  typedef struct packed {
    logic       fire;   // level settled after a change
    logic       level;  // new sampled level
    logic [2:0] fm;     // function slot match: bit0 start, bit1 F1, bit2 F2
  } lane_res_t;

  typedef struct packed {
    logic             scan_stop;
    logic             pressed;
    logic [KEY_W-1:0] key_index;
    logic             has_event;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_STATUS
  } st_e;

endpackage

// ===== rtl/kmds_lane.sv =====
// One key lane: debounce state and per-sample event decision.
module kmds_lane import kmds_pkg::*; #(
  parameter int IDX   = 0,
  parameter bit FN_EN = 1'b1
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      ld_i,
  input  logic      level_i,
  input  cfg_t      cfg_i,
  output lane_res_t res_o
);

  localparam logic [KEY_W-1:0] MY_IDX = KEY_W'(IDX);

  logic prev_q, prev_d;
  logic pend_q, pend_d;

  // Settled after change: pending and the new sample repeats the old one
  assign res_o.fire  = pend_q && (level_i == prev_q);
  assign res_o.level = level_i;

  if (FN_EN) begin : g_fn
    assign res_o.fm = {cfg_i.f2_slot == MY_IDX, cfg_i.f1_slot == MY_IDX,
                       cfg_i.start_slot == MY_IDX};
  end else begin : g_plain
    assign res_o.fm = 3'b000;
  end

  // A change arms pending; a repeat clears it
  always_comb begin
    prev_d = prev_q;
    pend_d = pend_q;
    if (ld_i) begin
      prev_d = level_i;
      pend_d = level_i ^ prev_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= 1'b0;
      pend_q <= 1'b0;
    end else begin
      prev_q <= prev_d;
      pend_q <= pend_d;
    end
  end

endmodule

// ===== rtl/kmds_merge.sv =====
// Merge sequencer: walks lane results in key order, combo flags, countdown, output register.
module kmds_merge import kmds_pkg::*; #(
  parameter int NKEYS      = 16,
  parameter int IDLE_TICKS = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_mode_i,
  output logic      in_ready_o,
  input  lane_res_t lane_i [NKEYS+1],
  input  cfg_t      cfg_i,
  output logic      tick_ld_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o,
  output logic      out_last_o
);

  localparam logic [CNT_W-1:0] IDLE_LD  = CNT_W'(IDLE_TICKS);
  localparam logic [KEY_W-1:0] LAST_IDX = KEY_W'(NKEYS);

  st_e              state_q, state_d;
  logic [KEY_W-1:0] idx_q, idx_d;
  lane_res_t        sh_q [NKEYS+1];
  logic [KEY_W-1:0] down_q;
  logic             idle_q;
  logic [2:0]       flags_q, flags_d;
  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_next;
  logic             active_q, active_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_item_q;
  logic             out_last_q;

  logic             accept, wake, out_free;
  logic [KEY_W-1:0] down_cnt;
  logic             busy;
  lane_res_t        cur;
  logic             emit, walk_go, stat_go, stop;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign wake       = accept && in_mode_i;
  assign tick_ld_o  = accept && !in_mode_i && active_q;
  assign out_free   = !out_valid_q || out_ready_i;

  // Keys down in the new sample, and whether anything is down at all
  always_comb begin
    down_cnt = '0;
    busy     = lane_i[NKEYS].level;
    for (int i = 0; i < NKEYS; i++) begin
      down_cnt = down_cnt + KEY_W'(lane_i[i].level);
      busy     = busy | lane_i[i].level;
    end
  end

  // Countdown after this tick
  always_comb begin
    if (!idle_q) begin
      cnt_next = IDLE_LD;
    end else if (cnt_q != '0) begin
      cnt_next = cnt_q - CNT_W'(1);
    end else begin
      cnt_next = '0;
    end
    stop = (cnt_next == '0);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (tick_ld_o) state_d = ST_WALK;
      end
      ST_WALK: begin
        if (walk_go && (idx_q == LAST_IDX)) state_d = ST_STATUS;
      end
      ST_STATUS: begin
        if (stat_go) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Step decision for the key at the head of the shift line
  always_comb begin
    cur     = sh_q[0];
    emit    = 1'b0;
    flags_d = flags_q;
    walk_go = 1'b0;
    stat_go = 1'b0;
    case (state_q)
      ST_WALK: begin
        if (cur.fire) begin
          if (!cur.level) begin
            // release of a function key clears one flag, start first
            if (cur.fm != 3'b000 && flags_q[0]) flags_d[0] = 1'b0;
            else if (cur.fm != 3'b000 && flags_q[1]) flags_d[1] = 1'b0;
            else if (cur.fm != 3'b000 && flags_q[2]) flags_d[2] = 1'b0;
            else emit = 1'b1;
          end else begin
            // press of a function key with enough keys down is swallowed
            if (cur.fm != 3'b000 && down_q >= cfg_i.combo_thr) flags_d = flags_q | cur.fm;
            else emit = 1'b1;
          end
        end
        walk_go = !emit || out_free;
        if (!walk_go) flags_d = flags_q;
      end
      ST_STATUS: stat_go = out_free;
      default: ;
    endcase
  end

  // Control next values
  always_comb begin
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    active_d    = active_q;
    out_valid_d = out_valid_q;
    if (tick_ld_o) idx_d = '0;
    else if (walk_go) idx_d = idx_q + KEY_W'(1);
    if (wake) begin
      cnt_d    = IDLE_LD;
      active_d = 1'b1;
    end else if (stat_go) begin
      cnt_d = cnt_next;
      if (stop) active_d = 1'b0;
    end
    if ((walk_go && emit) || stat_go) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      flags_q     <= '0;
      cnt_q       <= '0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      flags_q     <= flags_d;
      cnt_q       <= cnt_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Lane results: captured on a tick, shifted one key per step
  always_ff @(posedge clk_i) begin
    if (tick_ld_o) begin
      sh_q   <= lane_i;
      down_q <= down_cnt;
      idle_q <= !busy;
    end else if (walk_go) begin
      for (int i = 0; i < NKEYS; i++) sh_q[i] <= sh_q[i+1];
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (walk_go && emit) begin
      out_item_q.has_event <= 1'b1;
      out_item_q.key_index <= (idx_q == LAST_IDX) ? SPECIAL_INDEX : idx_q;
      out_item_q.pressed   <= cur.level;
      out_item_q.scan_stop <= 1'b0;
      out_last_q           <= 1'b0;
    end else if (stat_go) begin
      out_item_q.has_event <= 1'b0;
      out_item_q.key_index <= '0;
      out_item_q.pressed   <= 1'b0;
      out_item_q.scan_stop <= stop;
      out_last_q           <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;
  assign out_last_o  = out_last_q;

endmodule

// ===== rtl/keypad_matrix_debounce_scanner.sv =====
// Top level of the keypad matrix debounce scanner: config registers, key lanes, merge.
//
//   channel   direction  handshake               payload
//   s_axis    in         s_axis_tvalid/tready    tdata levels+special, tuser mode
//   m_axis    out        m_axis_tvalid/tready    tdata event fields, tlast end of tick
//   apb       in         psel/penable/pready     four 5-bit registers at 4*i
//
// A wake item is accepted while idle and starts no walk. A scan tick runs accept,
// one merge step per matrix key and one for the special key, then the status item;
// the merge sequencer visits one lane a cycle unless an output stall holds it.
// Output stalls hold the walk on steps that emit and hold the status item. Reset
// clears all key state, flags and the countdown, and no clearing pass is needed.
module keypad_matrix_debounce_scanner import kmds_pkg::*; #(
  parameter int ROWS       = 4,
  parameter int COLS       = 4,
  parameter int IDLE_TICKS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [15:0] key_levels, [16] special_level, rest zero
  input  logic        s_axis_tuser,  // [0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [0] has_event, [5:1] key_index, [6] pressed,
                                     // [7] scan_stop
  output logic        m_axis_tlast,  // last
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NKEYS = (ROWS * COLS > 16) ? 16 : ROWS * COLS;

  cfg_t      cfg_q, cfg_d;
  lane_res_t lane_res [NKEYS+1];
  logic      tick_ld;
  out_item_t out_item;
  logic      cfg_wr;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      case (paddr[3:2])
        REG_START_SLOT: cfg_d.start_slot = pwdata[KEY_W-1:0];
        REG_F1_SLOT:    cfg_d.f1_slot    = pwdata[KEY_W-1:0];
        REG_F2_SLOT:    cfg_d.f2_slot    = pwdata[KEY_W-1:0];
        REG_COMBO_THR:  cfg_d.combo_thr  = pwdata[KEY_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_slot <= SLOT_NONE;
      cfg_q.f1_slot    <= SLOT_NONE;
      cfg_q.f2_slot    <= SLOT_NONE;
      cfg_q.combo_thr  <= THR_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Register readback
  always_comb begin
    case (paddr[3:2])
      REG_START_SLOT: prdata = 32'(cfg_q.start_slot);
      REG_F1_SLOT:    prdata = 32'(cfg_q.f1_slot);
      REG_F2_SLOT:    prdata = 32'(cfg_q.f2_slot);
      REG_COMBO_THR:  prdata = 32'(cfg_q.combo_thr);
      default:        prdata = '0;
    endcase
  end

  // Matrix key lanes
  for (genvar g = 0; g < NKEYS; g++) begin : g_lane
    kmds_lane #(
      .IDX   (g),
      .FN_EN (1'b1)
    ) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ld_i    (tick_ld),
      .level_i (s_axis_tdata[g]),
      .cfg_i   (cfg_q),
      .res_o   (lane_res[g])
    );
  end

  // Special key lane, never a function key
  kmds_lane #(
    .IDX   (16),
    .FN_EN (1'b0)
  ) u_special (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ld_i    (tick_ld),
    .level_i (s_axis_tdata[16]),
    .cfg_i   (cfg_q),
    .res_o   (lane_res[NKEYS])
  );

  kmds_merge #(
    .NKEYS      (NKEYS),
    .IDLE_TICKS (IDLE_TICKS)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_mode_i   (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .lane_i      (lane_res),
    .cfg_i       (cfg_q),
    .tick_ld_o   (tick_ld),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_item_o  (out_item),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {out_item.scan_stop, out_item.pressed, out_item.key_index,
                         out_item.has_event};

endmodule
